/* hw/rtl/s7pk_pkg.sv */
// Package for the sysex7 payload packetizer: sizes, codes, state type and
// the command and status structs between controller and datapath.
// No dependencies.
package s7pk_pkg;

  // Payload store depth and packet size.
  localparam int MAX_PAYLOAD_BYTES = 256;
  localparam int BYTES_PER_PACKET  = 6;

  // Derived widths.
  localparam int CNT_W  = $clog2(MAX_PAYLOAD_BYTES + 1);
  localparam int ADDR_W = $clog2(MAX_PAYLOAD_BYTES);
  localparam int SLOT_W = $clog2(BYTES_PER_PACKET + 1);
  localparam int BYTE_W = 7;
  localparam int TS_W   = 64;
  localparam int GRP_W  = 4;

  // Stream widths.
  localparam int IN_DATA_W  = 80;
  localparam int OUT_DATA_W = 120;
  localparam int OUT_USER_W = 4;

  // Packet status codes.
  typedef enum logic [1:0] {
    ST_COMPLETE = 2'd0,
    ST_START    = 2'd1,
    ST_CONTINUE = 2'd2,
    ST_END      = 2'd3
  } pkt_status_t;

  // Error codes.
  typedef enum logic [1:0] {
    ERR_NONE     = 2'd0,
    ERR_HIGH_BIT = 2'd1,
    ERR_OVERFLOW = 2'd2
  } err_code_t;

  // Controller states.
  typedef enum logic [2:0] {
    S_COLLECT,
    S_CHECK,
    S_BEGIN,
    S_FETCH,
    S_SEND
  } state_t;

  // Commands from controller to datapath.
  typedef struct packed {
    logic take;       // input beat accepted
    logic load_err;   // load the error result
    logic begin_pkt;  // set up the next packet
    logic fetch;      // read stored bytes into the packet
    logic advance;    // step to the next packet
    logic clear_msg;  // message done, clear counters
  } cmd_t;

  // Status from datapath to controller.
  typedef struct packed {
    logic err;         // message has an error
    logic fetch_done;  // all bytes of the packet are in place
    logic last;        // current result is the final one
  } sts_t;

endpackage

/* hw/rtl/sysex7_payload_packetizer.sv */
// Top level of the sysex7 payload packetizer: joins the controller and the
// datapath. Depends on s7pk_pkg, s7pk_ctrl and s7pk_datapath.
//
//  channel | dir | tdata / tuser / tlast
//  in_     | in  | tdata: byte, group, timestamp; tuser: has_byte; tlast: end
//  out_    | out | tdata: timestamp..bytes; tuser: status, error; tlast: last
//
// Payload bytes are taken one beat per cycle while collecting. After the end
// beat the controller checks for errors; an error result follows at once. Each
// packet then goes through setup, one memory read per byte, a final capture and
// output, plus any stall on the output. No input is taken while results are emitted.
// Reset clears control state only; the payload memory needs no clearing.
module sysex7_payload_packetizer
  import s7pk_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // [7:0] data_byte, [11:8] group, [75:12] timestamp, [79:76] zero
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // [0] has_byte
  input  logic                  in_tuser,
  input  logic                  in_tlast,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // [63:0] packet_timestamp, [67:64] packet_group, [70:68] byte_count,
  // [77:71] byte_zero, [84:78] byte_one, [91:85] byte_two,
  // [98:92] byte_three, [105:99] byte_four, [112:106] byte_five, [119:113] zero
  output logic [OUT_DATA_W-1:0] out_tdata,
  // [1:0] packet_status, [3:2] error_code
  output logic [OUT_USER_W-1:0] out_tuser,
  output logic                  out_tlast
);

  cmd_t cmd;
  sts_t sts;

  // Sequencing.
  s7pk_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tlast   (in_tlast),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  // Storage and packet assembly.
  s7pk_datapath u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tlast  (in_tlast),
    .cmd       (cmd),
    .sts       (sts),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  assign out_tlast = sts.last;

endmodule

/* hw/rtl/s7pk_ctrl.sv */
// Controller state machine of the sysex7 payload packetizer.
// Depends on s7pk_pkg.
module s7pk_ctrl
  import s7pk_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  input  logic in_tlast,
  output logic in_tready,
  output logic out_tvalid,
  input  logic out_tready,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state_r;
  state_t state_nxt;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_COLLECT;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands.
  always_comb begin
    state_nxt  = state_r;
    cmd        = '0;
    in_tready  = 1'b0;
    out_tvalid = 1'b0;
    unique case (state_r)
      S_COLLECT: begin
        in_tready = 1'b1;
        cmd.take  = in_tvalid;
        if (in_tvalid && in_tlast) begin
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (sts.err) begin
          cmd.load_err = 1'b1;
          state_nxt    = S_SEND;
        end else begin
          state_nxt = S_BEGIN;
        end
      end
      S_BEGIN: begin
        cmd.begin_pkt = 1'b1;
        state_nxt     = S_FETCH;
      end
      S_FETCH: begin
        cmd.fetch = 1'b1;
        if (sts.fetch_done) begin
          state_nxt = S_SEND;
        end
      end
      S_SEND: begin
        out_tvalid = 1'b1;
        if (out_tready) begin
          if (sts.last) begin
            cmd.clear_msg = 1'b1;
            state_nxt     = S_COLLECT;
          end else begin
            cmd.advance = 1'b1;
            state_nxt   = S_BEGIN;
          end
        end
      end
      default: begin
        state_nxt = S_COLLECT;
      end
    endcase
  end

  // The two channels never move in the same cycle.
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid))
    else $error("input and output active together");

  // After the final result the block collects again.
  a_back_to_collect: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tready && sts.last) |=> in_tready)
    else $error("not back to collecting after final result");

  // An end beat leads to the error check.
  a_end_to_check: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && in_tlast) |=> (state_r == S_CHECK))
    else $error("end beat did not start emission");

endmodule

/* hw/rtl/s7pk_datapath.sv */
// Datapath of the sysex7 payload packetizer: payload memory, counters,
// packet assembly and the output register. Depends on s7pk_pkg.
module s7pk_datapath
  import s7pk_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [IN_DATA_W-1:0]  in_tdata,
  input  logic                  in_tuser,
  input  logic                  in_tlast,
  input  cmd_t                  cmd,
  output sts_t                  sts,
  output logic [OUT_DATA_W-1:0] out_tdata,
  output logic [OUT_USER_W-1:0] out_tuser
);

  localparam logic [CNT_W-1:0]  MaxCnt  = CNT_W'(MAX_PAYLOAD_BYTES);
  localparam logic [CNT_W-1:0]  PktCnt  = CNT_W'(BYTES_PER_PACKET);
  localparam logic [SLOT_W-1:0] PktSlot = SLOT_W'(BYTES_PER_PACKET);
  localparam int PAD_W = OUT_DATA_W - TS_W - GRP_W - SLOT_W - BYTES_PER_PACKET * BYTE_W;

  // Input fields.
  logic [7:0]       in_byte;
  logic [GRP_W-1:0] in_grp;
  logic [TS_W-1:0]  in_ts;
  assign in_byte = in_tdata[7:0];
  assign in_grp  = in_tdata[11:8];
  assign in_ts   = in_tdata[75:12];

  // Message state.
  logic [CNT_W-1:0]  total_r;
  logic              bad_r;
  logic              ovf_r;
  logic [CNT_W-1:0]  base_r;
  logic [TS_W-1:0]   ts_r;
  logic [GRP_W-1:0]  grp_r;

  // Packet state.
  logic [SLOT_W-1:0] cnt_r;
  logic [SLOT_W-1:0] k_r;
  logic              pipe_r;
  logic [SLOT_W-1:0] pslot_r;
  logic [BYTE_W-1:0] slot_r [BYTES_PER_PACKET];
  pkt_status_t       status_r;
  err_code_t         code_r;
  logic              last_r;

  // Payload memory.
  logic [BYTE_W-1:0] payload_mem_r [MAX_PAYLOAD_BYTES];
  logic [BYTE_W-1:0] rdata_r;
  logic              wr_en;
  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;
  logic [CNT_W-1:0]  rd_sum;

  assign wr_en   = cmd.take && in_tuser && (total_r < MaxCnt);
  assign rd_en   = cmd.fetch && (k_r < cnt_r);
  assign rd_sum  = base_r + CNT_W'(k_r);
  assign rd_addr = rd_sum[ADDR_W-1:0];

  // Memory write and registered read.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      payload_mem_r[total_r[ADDR_W-1:0]] <= in_byte[BYTE_W-1:0];
    end
    if (rd_en) begin
      rdata_r <= payload_mem_r[rd_addr];
    end
  end

  // Fields of the packet that starts at base_r.
  logic [CNT_W-1:0]  rem_c;
  logic [SLOT_W-1:0] count_c;
  logic              last_c;
  logic              first_c;
  pkt_status_t       status_c;

  always_comb begin
    rem_c   = total_r - base_r;
    last_c  = (rem_c <= PktCnt);
    first_c = (base_r == '0);
    count_c = last_c ? rem_c[SLOT_W-1:0] : PktSlot;
    priority if (first_c && last_c) begin
      status_c = ST_COMPLETE;
    end else if (first_c) begin
      status_c = ST_START;
    end else if (last_c) begin
      status_c = ST_END;
    end else begin
      status_c = ST_CONTINUE;
    end
  end

  // Message counters and flags.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r <= '0;
      bad_r   <= 1'b0;
      ovf_r   <= 1'b0;
      base_r  <= '0;
    end else begin
      if (cmd.take && in_tuser) begin
        if (in_byte[7]) begin
          bad_r <= 1'b1;
        end
        if (total_r < MaxCnt) begin
          total_r <= total_r + CNT_W'(1);
        end else begin
          ovf_r <= 1'b1;
        end
      end
      if (cmd.take && in_tlast) begin
        base_r <= '0;
      end
      if (cmd.advance) begin
        base_r <= base_r + PktCnt;
      end
      if (cmd.clear_msg) begin
        total_r <= '0;
        bad_r   <= 1'b0;
        ovf_r   <= 1'b0;
      end
    end
  end

  // Sampled group and timestamp.
  always_ff @(posedge clk) begin
    if (cmd.take && in_tlast) begin
      ts_r  <= in_ts;
      grp_r <= in_grp;
    end
  end

  // Fetch control.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_r    <= '0;
      pipe_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      if (cmd.begin_pkt) begin
        k_r    <= '0;
        pipe_r <= 1'b0;
        cnt_r  <= count_c;
      end else if (cmd.load_err) begin
        k_r    <= '0;
        pipe_r <= 1'b0;
        cnt_r  <= '0;
      end else if (cmd.fetch) begin
        pipe_r <= rd_en;
        if (rd_en) begin
          k_r <= k_r + SLOT_W'(1);
        end
      end
    end
  end

  // Packet payload and header fields.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      pslot_r <= k_r;
    end
    if (cmd.begin_pkt || cmd.load_err) begin
      for (int i = 0; i < BYTES_PER_PACKET; i++) begin
        slot_r[i] <= '0;
      end
    end else if (cmd.fetch && pipe_r) begin
      slot_r[pslot_r] <= rdata_r;
    end
    if (cmd.begin_pkt) begin
      status_r <= status_c;
      last_r   <= last_c;
      code_r   <= ERR_NONE;
    end else if (cmd.load_err) begin
      status_r <= ST_COMPLETE;
      last_r   <= 1'b1;
      code_r   <= bad_r ? ERR_HIGH_BIT : ERR_OVERFLOW;
    end
  end

  // Status to the controller.
  assign sts.err        = bad_r || ovf_r;
  assign sts.fetch_done = (k_r == cnt_r);
  assign sts.last       = last_r;

  // Output beat.
  assign out_tdata = {PAD_W'(0), slot_r[5], slot_r[4], slot_r[3], slot_r[2], slot_r[1],
                      slot_r[0], cnt_r, grp_r, ts_r};
  assign out_tuser = {code_r, status_r};

  // The byte count never passes the store size.
  a_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
    total_r <= MaxCnt)
    else $error("byte total beyond store size");

  // The fetch index stays within the packet.
  a_fetch_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (k_r <= cnt_r) && (cnt_r <= PktSlot))
    else $error("fetch index beyond packet");

  // A read is always followed by its capture.
  a_read_capture: assert property (@(posedge clk) disable iff (!rst_n)
    rd_en |=> (pipe_r && cmd.fetch))
    else $error("read data not captured");

endmodule
